@@ rtl/chd_pkg.sv @@
package chd_pkg;

  // Widths fixed by the port list
  localparam int LIMIT_W = 32;
  localparam int LEN_W   = 32;
  localparam int ACC_W   = LIMIT_W + 1;

  // Default width of the body byte counter
  localparam int COUNT_BITS_DEF = 32;

  // Chunk size limit after reset: 10 MiB
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(10 * 1024 * 1024);

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_DONE    = 3'd1,
    ST_BADHEX  = 3'd2,
    ST_LIMIT   = 3'd3,
    ST_NOCRLF  = 3'd4,
    ST_TRAILER = 3'd5
  } status_t;

  // One request held in the input register
  typedef struct packed {
    logic       vld;
    logic       start;
    logic [7:0] data;
  } item_t;

endpackage

@@ rtl/http_chunked_body_decoder.sv @@
// Chunked transfer body decoder. Feed the raw body one byte per request on the
// in_ channel; each request gives exactly one result on the out_ channel, carrying
// the decoded data byte (out_data_valid high for chunk payload bytes only), the
// sticky status (busy, done, bad hex, over limit, missing CRLF, trailer) and the
// running body byte count. Set in_start_message on the first byte of a message to
// restart the parser. The block takes one byte every clock unless a waiting result
// is held by out_stall: a byte is held in the input register and then parsed into
// the result register, so each result passes through these two registers and the
// state machine update is the only loop. Write the chunk size limit through
// cfg_wr_en/cfg_wr_data only while no request is in flight.
module http_chunked_body_decoder #(
  parameter int COUNT_BITS = chd_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [chd_pkg::LIMIT_W-1:0] cfg_wr_data,
  // raw byte requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_start_message,
  input  logic [7:0]                  in_byte,
  // decoded results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_data_valid,
  output logic [7:0]                  out_data_byte,
  output logic [2:0]                  out_status,
  output logic [chd_pkg::LEN_W-1:0]   out_body_length
);

  logic [chd_pkg::LIMIT_W-1:0] limit_r;
  chd_pkg::item_t              item;
  logic                        take;

  // Chunk size limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= chd_pkg::LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Input register: holds a request while the result side stalls
  chd_in_stage u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_start_message (in_start_message),
    .in_byte          (in_byte),
    .take             (take),
    .in_stall         (in_stall),
    .item             (item)
  );

  // Framing state machine, counters and result register
  chd_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .item            (item),
    .limit           (limit_r),
    .out_stall       (out_stall),
    .take            (take),
    .out_valid       (out_valid),
    .out_data_valid  (out_data_valid),
    .out_data_byte   (out_data_byte),
    .out_status      (out_status),
    .out_body_length (out_body_length)
  );

endmodule

@@ rtl/chd_in_stage.sv @@
module chd_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_start_message,
  input  logic [7:0]    in_byte,
  input  logic          take,
  output logic          in_stall,
  output chd_pkg::item_t item
);

  logic       vld_r;
  logic       start_r;
  logic [7:0] data_r;
  logic       load;

  // Hold the request while the parser cannot take it
  assign in_stall = vld_r && !take;
  assign load     = !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      start_r <= in_start_message;
      data_r  <= in_byte;
    end
  end

  assign item.vld   = vld_r;
  assign item.start = start_r;
  assign item.data  = data_r;

endmodule

@@ rtl/chd_parser.sv @@
module chd_parser #(
  parameter int COUNT_BITS = chd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  chd_pkg::item_t                item,
  input  logic [chd_pkg::LIMIT_W-1:0]   limit,
  input  logic                          out_stall,
  output logic                          take,
  output logic                          out_valid,
  output logic                          out_data_valid,
  output logic [7:0]                    out_data_byte,
  output logic [2:0]                    out_status,
  output logic [chd_pkg::LEN_W-1:0]     out_body_length
);

  localparam int CntW  = (COUNT_BITS >= 32) ? 32 : COUNT_BITS;
  localparam int GrowW = chd_pkg::ACC_W + 4;

  typedef enum logic [8:0] {
    PH_SIZE    = 9'b000000001,
    PH_EXT     = 9'b000000010,
    PH_SIZE_LF = 9'b000000100,
    PH_DATA    = 9'b000001000,
    PH_DATA_CR = 9'b000010000,
    PH_DATA_LF = 9'b000100000,
    PH_FIN_CR  = 9'b001000000,
    PH_FIN_LF  = 9'b010000000,
    PH_STOP    = 9'b100000000
  } phase_t;

  phase_t                        phase_r, phase_nxt, ph;
  logic [chd_pkg::ACC_W-1:0]     acc_r, acc_nxt, acc;
  logic [chd_pkg::LIMIT_W-1:0]   left_r, left_nxt, left;
  logic [CntW-1:0]               cnt_r, cnt_nxt, cnt;
  chd_pkg::status_t              status_r, status_nxt, st;
  logic                          out_valid_r;
  logic                          dv_r, dv_nxt;
  logic [7:0]                    db_r, db_nxt;
  logic                          adv;
  logic                          hex_ok;
  logic [3:0]                    hex_val;
  logic [GrowW-1:0]              grown;

  // Hex digit decode, either case
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (item.data >= 8'h30 && item.data <= 8'h39) begin
      hex_val = 4'(item.data - 8'h30);
    end else if (item.data >= 8'h41 && item.data <= 8'h46) begin
      hex_val = 4'(item.data - 8'h37);
    end else if (item.data >= 8'h61 && item.data <= 8'h66) begin
      hex_val = 4'(item.data - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign take = !out_valid_r || !out_stall;
  assign adv  = item.vld && take;

  always_comb begin
    // Restart clears the state before this byte is parsed
    ph   = item.start ? PH_SIZE : phase_r;
    acc  = item.start ? '0 : acc_r;
    left = item.start ? '0 : left_r;
    cnt  = item.start ? '0 : cnt_r;
    st   = item.start ? chd_pkg::ST_BUSY : status_r;

    phase_nxt  = ph;
    acc_nxt    = acc;
    left_nxt   = left;
    cnt_nxt    = cnt;
    status_nxt = st;
    dv_nxt     = 1'b0;
    db_nxt     = 8'd0;
    grown      = {acc, hex_val};

    unique case (ph)
      PH_SIZE: begin
        if (hex_ok) begin
          if (grown > GrowW'(limit)) begin
            acc_nxt = {1'b0, limit} + chd_pkg::ACC_W'(1);
          end else begin
            acc_nxt = grown[chd_pkg::ACC_W-1:0];
          end
        end else if (item.data == chd_pkg::CH_SEMI) begin
          phase_nxt = PH_EXT;
        end else if (item.data == chd_pkg::CH_CR) begin
          phase_nxt = PH_SIZE_LF;
        end else begin
          phase_nxt  = PH_STOP;
          status_nxt = chd_pkg::ST_BADHEX;
        end
      end
      PH_EXT: begin
        if (item.data == chd_pkg::CH_CR) begin
          phase_nxt = PH_SIZE_LF;
        end
      end
      PH_SIZE_LF: begin
        if (item.data != chd_pkg::CH_LF) begin
          phase_nxt  = PH_STOP;
          status_nxt = chd_pkg::ST_NOCRLF;
        end else if (acc == '0) begin
          phase_nxt = PH_FIN_CR;
        end else if (acc > {1'b0, limit}) begin
          phase_nxt  = PH_STOP;
          status_nxt = chd_pkg::ST_LIMIT;
        end else begin
          left_nxt  = acc[chd_pkg::LIMIT_W-1:0];
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        dv_nxt = 1'b1;
        db_nxt = item.data;
        if (cnt != '1) begin
          cnt_nxt = cnt + 1'b1;
        end
        if (left != '0) begin
          left_nxt = left - 1'b1;
        end
        if (left_nxt == '0) begin
          phase_nxt = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (item.data == chd_pkg::CH_CR) begin
          phase_nxt = PH_DATA_LF;
        end else begin
          phase_nxt  = PH_STOP;
          status_nxt = chd_pkg::ST_NOCRLF;
        end
      end
      PH_DATA_LF: begin
        if (item.data == chd_pkg::CH_LF) begin
          phase_nxt = PH_SIZE;
          acc_nxt   = '0;
        end else begin
          phase_nxt  = PH_STOP;
          status_nxt = chd_pkg::ST_NOCRLF;
        end
      end
      PH_FIN_CR: begin
        phase_nxt = PH_STOP;
        if (item.data == chd_pkg::CH_CR) begin
          phase_nxt = PH_FIN_LF;
        end else begin
          status_nxt = chd_pkg::ST_TRAILER;
        end
      end
      PH_FIN_LF: begin
        phase_nxt = PH_STOP;
        if (item.data == chd_pkg::CH_LF) begin
          status_nxt = chd_pkg::ST_DONE;
        end else begin
          status_nxt = chd_pkg::ST_NOCRLF;
        end
      end
      PH_STOP: begin
      end
      default: begin
        phase_nxt = PH_STOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIZE;
      acc_r       <= '0;
      left_r      <= '0;
      cnt_r       <= '0;
      status_r    <= chd_pkg::ST_BUSY;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        phase_r  <= phase_nxt;
        acc_r    <= acc_nxt;
        left_r   <= left_nxt;
        cnt_r    <= cnt_nxt;
        status_r <= status_nxt;
      end
      if (take) begin
        out_valid_r <= item.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r <= dv_nxt;
      db_r <= db_nxt;
    end
  end

  // Status and count registers change only when a result is loaded
  assign out_valid       = out_valid_r;
  assign out_data_valid  = dv_r;
  assign out_data_byte   = db_r;
  assign out_status      = status_r;
  assign out_body_length = chd_pkg::LEN_W'(cnt_r);

  a_data_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dv_r |-> status_r == chd_pkg::ST_BUSY)
    else $error("data byte delivered with a final status");

  a_stop_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STOP) == (status_r != chd_pkg::ST_BUSY))
    else $error("stop phase and sticky status disagree");

  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> left_r != '0)
    else $error("data phase with no bytes left");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cnt_r))
    else $error("body count moved without a request");

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !item.start |=> cnt_r >= $past(cnt_r))
    else $error("body count went down without restart");

endmodule

@@ verif/chunk_decode_checker.sv @@
// Watches both channels of the chunked body decoder, predicts one result per
// accepted request and compares it with the results in order.
module chunk_decode_checker
  import chd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_start_message,
  input  logic [7:0]         in_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_data_valid,
  input  logic [7:0]         out_data_byte,
  input  logic [2:0]         out_status,
  input  logic [LEN_W-1:0]   out_body_length,
  output int                 mismatches,
  output int                 outstanding
);

  localparam logic [LEN_W-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    P_SIZE, P_EXT, P_SIZE_LF, P_DATA, P_DATA_CR, P_DATA_LF, P_FIN_CR, P_FIN_LF, P_STOP
  } phase_t;

  typedef struct packed {
    logic             dv;
    logic [7:0]       db;
    status_t          st;
    logic [LEN_W-1:0] len;
  } body_result_t;

  logic [LIMIT_W-1:0] limit_q;
  phase_t             phase;
  logic [ACC_W-1:0]   size_acc;
  logic [31:0]        bytes_left;
  logic [LEN_W-1:0]   body_cnt;
  status_t            sticky;
  body_result_t       expected_q[$];

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  task automatic clear_parse();
    phase      = P_SIZE;
    size_acc   = '0;
    bytes_left = '0;
    body_cnt   = '0;
    sticky     = ST_BUSY;
  endtask

  task automatic halt(status_t code);
    sticky = code;
    phase  = P_STOP;
  endtask

  // Advance the parser by one raw byte and return the result it produces.
  task automatic decode_byte(input logic start, input logic [7:0] c,
                             output body_result_t r);
    int          nib;
    logic [63:0] grown;
    r.dv = 1'b0;
    r.db = 8'd0;
    if (start) clear_parse();
    case (phase)
      P_SIZE: begin
        nib = hex_nibble(c);
        if (nib >= 0) begin
          grown = {31'd0, size_acc} * 64'd16 + 64'(nib);
          if (grown > {32'd0, limit_q}) size_acc = {1'b0, limit_q} + 33'd1;
          else size_acc = grown[ACC_W-1:0];
        end else if (c == CH_SEMI) begin
          phase = P_EXT;
        end else if (c == CH_CR) begin
          phase = P_SIZE_LF;
        end else begin
          halt(ST_BADHEX);
        end
      end
      P_EXT: begin
        if (c == CH_CR) phase = P_SIZE_LF;
      end
      P_SIZE_LF: begin
        if (c != CH_LF) halt(ST_NOCRLF);
        else if (size_acc == '0) phase = P_FIN_CR;
        else if (size_acc > {1'b0, limit_q}) halt(ST_LIMIT);
        else begin
          bytes_left = size_acc[31:0];
          phase      = P_DATA;
        end
      end
      P_DATA: begin
        r.dv = 1'b1;
        r.db = c;
        if (body_cnt != COUNT_MAX) body_cnt = body_cnt + 1'b1;
        if (bytes_left != 0) bytes_left = bytes_left - 1;
        if (bytes_left == 0) phase = P_DATA_CR;
      end
      P_DATA_CR: begin
        if (c == CH_CR) phase = P_DATA_LF;
        else halt(ST_NOCRLF);
      end
      P_DATA_LF: begin
        if (c == CH_LF) begin
          phase    = P_SIZE;
          size_acc = '0;
        end else begin
          halt(ST_NOCRLF);
        end
      end
      P_FIN_CR: begin
        if (c == CH_CR) phase = P_FIN_LF;
        else halt(ST_TRAILER);
      end
      P_FIN_LF: begin
        if (c == CH_LF) halt(ST_DONE);
        else halt(ST_NOCRLF);
      end
      default: phase = P_STOP;
    endcase
    r.st  = sticky;
    r.len = body_cnt;
  endtask

  task automatic flag(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endtask

  always @(posedge clk) begin
    body_result_t want;
    if (!rst_n) begin
      limit_q = LIMIT_RST;
      clear_parse();
      expected_q.delete();
    end else begin
      // Compare before pushing: a result never belongs to a same-edge request.
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $error("result with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          if (out_data_valid !== want.dv) flag("data_valid", want.dv, out_data_valid);
          if (out_data_byte !== want.db) flag("data_byte", want.db, out_data_byte);
          if (out_status !== want.st) flag("status", want.st, out_status);
          if (out_body_length !== want.len) flag("body_length", want.len, out_body_length);
        end
      end
      if (cfg_wr_en) limit_q = cfg_wr_data;
      if (in_valid && !in_stall) begin
        decode_byte(in_start_message, in_byte, want);
        expected_q.push_back(want);
      end
    end
    outstanding = expected_q.size();
  end

endmodule

@@ verif/http_chunked_body_decoder_test.sv @@
// Top of the decoder testbench: clock, reset, request stimulus, result stall
// pattern, limit register phases and the verdict. Prediction and comparison
// live in chunk_decode_checker.
module http_chunked_body_decoder_test;
  import chd_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1550;
  localparam int NUM_PHASES   = 7;

  // One raw byte request as the sender sees it
  typedef struct packed {
    logic       start;
    logic [7:0] b;
  } raw_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_start_message = 1'b0;
  logic [7:0]         in_byte = 8'd0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               out_data_valid;
  logic [7:0]         out_data_byte;
  logic [2:0]         out_status;
  logic [LEN_W-1:0]   out_body_length;

  int                 mismatches;
  int                 outstanding;
  int                 cycles = 0;
  int                 sent = 0;
  int                 stall_left = 0;
  bit                 tx_quiet = 1'b0;
  bit                 rx_quiet = 1'b0;
  logic [LIMIT_W-1:0] cur_limit = LIMIT_RST;
  raw_req_t           msg_q[$];

  http_chunked_body_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_message (in_start_message),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_valid   (out_data_valid),
    .out_data_byte    (out_data_byte),
    .out_status       (out_status),
    .out_body_length  (out_body_length)
  );

  chunk_decode_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_message (in_start_message),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_valid   (out_data_valid),
    .out_data_byte    (out_data_byte),
    .out_status       (out_status),
    .out_body_length  (out_body_length),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side back-pressure: mostly short stalls, now and then a long one,
  // and no new ones while rx_quiet is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                 : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 10) return "0" + 8'(nib);
    if ($urandom_range(0, 1) == 1) return "a" + 8'(nib - 10);
    return "A" + 8'(nib - 10);
  endfunction

  // Bias noise toward the bytes the parser cares about.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return hex_char(4'($urandom_range(0, 15)));
      1:       return CH_CR;
      2:       return CH_LF;
      3:       return CH_SEMI;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one request after a random gap and hold it until it is taken.
  task automatic send_req(input logic start, input logic [7:0] b);
    int gap;
    gap = 0;
    if (!tx_quiet) begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  gap = 0;
        [70:94]: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(10, 40);
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_start_message <= start;
    in_byte          <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic flush_msg();
    foreach (msg_q[i]) send_req(msg_q[i].start, msg_q[i].b);
    msg_q.delete();
  endtask

  task automatic put(input logic [7:0] b);
    msg_q.push_back('{start: 1'b0, b: b});
  endtask

  // Hold off the sender until every result is back, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = v;
    @(posedge clk);
  endtask

  // Emit a size in hex, random case, sometimes with leading zeros. A zero
  // size may come out as an empty size line.
  task automatic put_hex(input logic [63:0] v);
    logic [63:0] tmp;
    int          n;
    int          zeros;
    tmp = v;
    n = 0;
    while (tmp != 0) begin
      n++;
      tmp = tmp >> 4;
    end
    zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
    if (v == 0 && zeros == 0 && $urandom_range(0, 5) != 0) zeros = 1;
    repeat (zeros) put("0");
    for (int i = n - 1; i >= 0; i--) put(hex_char(v[4*i +: 4]));
  endtask

  // Optional chunk extension: anything but CR after the semicolon.
  task automatic put_ext();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      put(CH_SEMI);
      repeat ($urandom_range(0, 5)) begin
        b = 8'($urandom_range(0, 255));
        put(b == CH_CR ? "x" : b);
      end
    end
  endtask

  task automatic put_crlf();
    put(CH_CR);
    put(CH_LF);
  endtask

  // Build one mostly well-formed chunked body into msg_q, then damage some.
  task automatic build_message();
    int          chunks;
    int          size;
    int          upper;
    int          idx;
    int          roll;
    bit          oversize;
    logic [63:0] big;
    chunks   = $urandom_range(0, 3);
    oversize = 1'b0;
    for (int c = 0; c < chunks && !oversize; c++) begin
      if ($urandom_range(0, 19) == 0) begin
        // Size past the limit: the block stops after the size line.
        big = {32'd0, cur_limit} + 64'd1 + 64'($urandom_range(0, 255));
        put_hex(big);
        put_ext();
        put_crlf();
        oversize = 1'b1;
      end else begin
        upper = (cur_limit < 24) ? int'(cur_limit) : 24;
        if (upper == 0) upper = 1;
        size = $urandom_range(1, upper);
        if (cur_limit >= 300 && $urandom_range(0, 39) == 0) size = $urandom_range(100, 300);
        put_hex(64'(size));
        put_ext();
        put_crlf();
        repeat (size) put(8'($urandom_range(0, 255)));
        put_crlf();
      end
    end
    if (!oversize) begin
      put_hex(64'd0);
      put_ext();
      put_crlf();
      put_crlf();
    end
    msg_q[0].start = 1'b1;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      // corrupt one byte
      idx = $urandom_range(0, msg_q.size() - 1);
      msg_q[idx].b = pick_byte();
    end else if (roll < 16) begin
      // cut the body short
      idx = $urandom_range(1, msg_q.size());
      while (msg_q.size() > idx) void'(msg_q.pop_back());
    end else if (roll < 20 && !oversize) begin
      // trailer line after the last chunk
      msg_q[msg_q.size() - 2].b = 8'($urandom_range(0, 255));
    end else if (roll < 23) begin
      // restart in the middle
      msg_q[$urandom_range(0, msg_q.size() - 1)].start = 1'b1;
    end
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 8)) put(pick_byte());
    msg_q[0].start = 1'($urandom_range(0, 1));
  endtask

  initial begin
    logic [LIMIT_W-1:0] lim;
    int                 target;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: data bytes at both extremes, empty size line, sticky done,
    // bad hex, extension-only zero line then trailer, missing LF, bare LF.
    put("2"); put_crlf(); put(8'h00); put(8'hFF); put_crlf(); put_crlf(); put_crlf();
    put("q");
    msg_q[0].start = 1'b1;
    flush_msg();
    send_req(1'b1, "f");
    send_req(1'b0, "g");
    send_req(1'b1, CH_SEMI);
    send_req(1'b0, "a");
    send_req(1'b0, CH_CR);
    send_req(1'b0, CH_LF);
    send_req(1'b0, "T");
    send_req(1'b1, "1");
    send_req(1'b0, CH_CR);
    send_req(1'b0, "x");
    send_req(1'b1, CH_LF);

    // Random phases, each under its own limit setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       lim = LIMIT_RST;
        1:       lim = 32'd1;
        2:       lim = 32'hFFFF_FFFF;
        3:       lim = 32'd0;
        4:       lim = 32'd16;
        5:       lim = 32'($urandom_range(2, 64));
        default: lim = 32'($urandom);
      endcase
      // Reset already loaded the default; rewrite it anyway once.
      write_limit(lim);
      target = sent + RANDOM_ITEMS / NUM_PHASES;
      while (sent < target) begin
        if ($urandom_range(0, 15) == 0) tx_quiet = ~tx_quiet;
        if ($urandom_range(0, 15) == 0) rx_quiet = ~rx_quiet;
        if ($urandom_range(0, 9) == 0) build_noise();
        else build_message();
        flush_msg();
        if (ph == 2 && sent >= target - 50 && sent < target - 30) drain();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ http_chunked_body_decoder.f @@
rtl/chd_pkg.sv
rtl/chd_in_stage.sv
rtl/chd_parser.sv
rtl/http_chunked_body_decoder.sv
verif/chunk_decode_checker.sv
verif/http_chunked_body_decoder_test.sv
